/* hw/rtl/pce_pkg.sv */
`default_nettype none
package pce_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MODE = 1'b0;

   localparam int CH_W   = 8;
   localparam int COEF_W = 12;
   localparam int PROD_W = COEF_W + CH_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int SUM_W  = CH_W + 2;
   localparam int GPROD_W = 19;

   localparam logic [CH_W-1:0] CH_MAX   = 8'd255;
   localparam logic [CH_W-1:0] TINT_G   = 8'd165;
   localparam logic [CH_W-1:0] NOIR_LVL = 8'd135;

   // Q12 sepia weights, [out channel][source channel]; channels 0 blue, 1 green, 2 red
   localparam logic [2:0][2:0][COEF_W-1:0] SEPIA_COEF = {
      {12'd1610, 12'd3150, 12'd774},
      {12'd1430, 12'd2810, 12'd688},
      {12'd1114, 12'd2187, 12'd537}
   };
   localparam logic [ACC_W-1:0] SEPIA_ROUND = 21'd2048;
   localparam int SEPIA_SHIFT = 12;

   // floor(s/3) == (s * 683) >> 11 for every s up to 765
   localparam logic [SUM_W-1:0] GRAY_RECIP = 10'd683;
   localparam int GRAY_SHIFT = 11;

   typedef enum logic [3:0] {
      MODE_INVERT    = 4'd0,
      MODE_GRAY      = 4'd1,
      MODE_SEPIA     = 4'd2,
      MODE_BW        = 4'd3,
      MODE_TINT      = 4'd4,
      MODE_RED       = 4'd5,
      MODE_GREEN     = 4'd6,
      MODE_BLUE      = 4'd7,
      MODE_YELLOW    = 4'd8,
      MODE_NOIR      = 4'd9,
      MODE_MOONLIGHT = 4'd10,
      MODE_COLORPOP  = 4'd11,
      MODE_SUNSET    = 4'd12,
      MODE_DUSK      = 4'd13
   } mode_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
      logic            last;
   } pix_type;

   typedef struct packed {
      logic [2:0][2:0][PROD_W-1:0] prod;
      logic [SUM_W-1:0]            sum;
      pix_type                     pix;
   } s1_type;

   typedef struct packed {
      logic [2:0][ACC_W-1:0] acc;
      logic [GPROD_W-1:0]    gprod;
      pix_type               pix;
   } s2_type;

endpackage
`default_nettype wire

/* hw/rtl/pce_stream_if.sv */
`default_nettype none
interface pce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue_in;
   logic [7:0] green_in;
   logic [7:0] red_in;
   logic       last_in;

   modport source (output valid, blue_in, green_in, red_in, last_in, input ready);
   modport sink (input valid, blue_in, green_in, red_in, last_in, output ready);
endinterface

interface pce_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue_out;
   logic [7:0] green_out;
   logic [7:0] red_out;
   logic       last_out;

   modport source (output valid, blue_out, green_out, red_out, last_out, input ready);
   modport sink (input valid, blue_out, green_out, red_out, last_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pce_csr.sv */
`default_nettype none
module pce_csr
   import pce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic [3:0]            mode
);

   logic [3:0] mode_ff;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == CSR_IDX_MODE);
   assign mode   = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 4'd0;
      end else if (wr_en) begin
         mode_ff <= pwdata[3:0];
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == CSR_IDX_MODE) begin
         prdata = {28'd0, mode_ff};
      end
   end

`ifndef SYNTHESIS
   a_reset_mode: assert property (@(posedge clock) reset |=> mode_ff == 4'd0)
      else $error("mode not cleared by reset");
   a_write_mode: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> mode_ff == $past(pwdata[3:0]))
      else $error("mode write lost");
`endif

endmodule
`default_nettype wire

/* hw/rtl/pce_product_stage.sv */
`default_nettype none
module pce_product_stage
   import pce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  pix_type in_pix,
   output logic    out_valid,
   input  logic    out_ready,
   output s1_type  out_data
);

   logic   valid_ff;
   s1_type data_ff;
   s1_type data_in;
   logic [2:0][CH_W-1:0] src;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign src = {in_pix.red, in_pix.green, in_pix.blue};

   always_comb begin
      data_in.pix = in_pix;
      data_in.sum = SUM_W'(in_pix.blue) + SUM_W'(in_pix.green) + SUM_W'(in_pix.red);
      for (int c = 0; c < 3; c++) begin
         for (int s = 0; s < 3; s++) begin
            data_in.prod[c][s] = PROD_W'(SEPIA_COEF[c][s]) * PROD_W'(src[s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/pce_sum_stage.sv */
`default_nettype none
module pce_sum_stage
   import pce_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  s1_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output s2_type out_data
);

   logic   valid_ff;
   s2_type data_ff;
   s2_type data_in;
   logic [GPROD_W-1:0] gprod_full;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign gprod_full = GPROD_W'(in_data.sum) * GPROD_W'(GRAY_RECIP);

   always_comb begin
      data_in.pix   = in_data.pix;
      data_in.gprod = gprod_full;
      for (int c = 0; c < 3; c++) begin
         data_in.acc[c] = ACC_W'(in_data.prod[c][0]) + ACC_W'(in_data.prod[c][1])
                        + ACC_W'(in_data.prod[c][2]) + SEPIA_ROUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/pce_select_stage.sv */
`default_nettype none
module pce_select_stage
   import pce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [3:0] mode,
   input  logic       in_valid,
   output logic       in_ready,
   input  s2_type     in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output pix_type    out_pix
);

   logic    valid_ff;
   pix_type pix_ff;
   pix_type pix_in;
   logic [2:0][CH_W-1:0] sepia;
   logic [CH_W:0]        scaled;
   logic [CH_W-1:0]      gray;
   logic [CH_W-1:0]      b, g, r;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;
   assign gray = in_data.gprod[GRAY_SHIFT +: CH_W];
   assign b = in_data.pix.blue;
   assign g = in_data.pix.green;
   assign r = in_data.pix.red;

   always_comb begin
      scaled = '0;
      for (int c = 0; c < 3; c++) begin
         scaled   = in_data.acc[c][SEPIA_SHIFT +: CH_W+1];
         sepia[c] = scaled[CH_W] ? CH_MAX : scaled[CH_W-1:0];
      end
   end

   always_comb begin
      pix_in = in_data.pix;
      case (mode_type'(mode))
         MODE_INVERT: begin
            pix_in.blue  = ~b;
            pix_in.green = ~g;
            pix_in.red   = ~r;
         end
         MODE_GRAY: begin
            pix_in.blue  = gray;
            pix_in.green = gray;
            pix_in.red   = gray;
         end
         MODE_SEPIA: begin
            pix_in.blue  = sepia[0];
            pix_in.green = sepia[1];
            pix_in.red   = sepia[2];
         end
         MODE_BW: begin
            pix_in.blue  = r;
            pix_in.green = r;
         end
         MODE_TINT: begin
            pix_in.green = TINT_G;
            pix_in.red   = CH_MAX;
         end
         MODE_RED: begin
            pix_in.blue  = '0;
            pix_in.green = '0;
         end
         MODE_GREEN: begin
            pix_in.blue = '0;
            pix_in.red  = '0;
         end
         MODE_BLUE: begin
            pix_in.green = '0;
            pix_in.red   = '0;
         end
         MODE_YELLOW: begin
            pix_in.green = CH_MAX;
            pix_in.red   = CH_MAX;
         end
         MODE_NOIR: begin
            pix_in.green = NOIR_LVL;
            pix_in.red   = NOIR_LVL;
         end
         MODE_MOONLIGHT: begin
            pix_in.green = '0;
            pix_in.red   = r >> 1;
         end
         MODE_COLORPOP: begin
            pix_in.green = '0;
            pix_in.blue  = b >> 1;
         end
         MODE_SUNSET: begin
            pix_in.blue  = '0;
            pix_in.green = g >> 1;
         end
         MODE_DUSK: begin
            pix_in.red   = '0;
            pix_in.green = g >> 1;
         end
         // the two spare codes pass the pixel through
         default: pix_in = in_data.pix;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pix_ff <= pix_in;
      end
   end

`ifndef SYNTHESIS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> valid_ff)
      else $error("loaded word not presented");
`endif

endmodule
`default_nettype wire

/* hw/rtl/pixel_color_effect_top.sv */
`default_nettype none
// Per-pixel color effect on a BGR stream, one word per clock while the output is not stalled.
// Each word passes three register stages in order (constant-weight products, sepia sums and
// gray scaling, effect select with saturation), the last of which drives rsp.valid; a stalled
// output backs up stage by stage, and req.ready falls only when all three stages hold a word
// and rsp is not taken. The effect is chosen by the effect_mode register at byte address 0 of
// the APB port and must be written while the pipeline is empty.
module pixel_color_effect_top
   import pce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pce_req_if.sink               req,
   pce_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [3:0] effect_mode;
   pix_type    req_pix;
   pix_type    rsp_pix;
   s1_type     s1_data;
   s2_type     s2_data;
   logic       s1_valid, s1_ready;
   logic       s2_valid, s2_ready;

   pce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .mode    (effect_mode)
   );

   assign req_pix.blue  = req.blue_in;
   assign req_pix.green = req.green_in;
   assign req_pix.red   = req.red_in;
   assign req_pix.last  = req.last_in;

   pce_product_stage u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_pix    (req_pix),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   pce_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   pce_select_stage u_select (
      .clock     (clock),
      .reset     (reset),
      .mode      (effect_mode),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_pix   (rsp_pix)
   );

   assign rsp.blue_out  = rsp_pix.blue;
   assign rsp.green_out = rsp_pix.green;
   assign rsp.red_out   = rsp_pix.red;
   assign rsp.last_out  = rsp_pix.last;

`ifndef SYNTHESIS
   // back-pressure only when every stage is full and the output is held
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid && s2_valid && rsp.valid && !rsp.ready))
      else $error("input stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire
